// File: src/assert_macros.svh
// assertion macros shared by the rate limiter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every clock edge outside of reset
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/prcl_pkg.sv
// shared types and constants of the per-class rate limiter
package prcl_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int NUM_CLASSES = 3;
	localparam int NUM_REGS    = 3;
	localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int IDX_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int KIND_W      = 3;
	localparam int VERDICT_W   = 2;
	localparam int STEP_W      = $clog2(COUNT_WIDTH + 1);
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 8;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [VERDICT_W-1:0]   verdict_t;

	localparam count_t CNT_MAX = {COUNT_WIDTH{1'b1}};

	// verdict codes
	localparam verdict_t VERDICT_PASS = 2'd0;
	localparam verdict_t VERDICT_DROP = 2'd1;
	localparam verdict_t VERDICT_NA   = 2'd2;

	// command codes carried in tuser
	localparam logic CMD_MSG  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSG,
		ST_MSG_DIV,
		ST_TICK,
		ST_TICK_DIV,
		ST_RESULT
	} state_t;

	// request to the shared divider
	typedef struct packed {
		logic   start;
		count_t dividend;
		count_t divisor;
	} div_req_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: src/prcl_div.sv
// shared restoring divider, one quotient bit per cycle
module prcl_div
	import prcl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat,
	output count_t    quot,
	output count_t    rem
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	count_t            rem_q;
	count_t            quot_q;
	count_t            dvs_q;
	logic [COUNT_WIDTH:0] shifted;
	logic [COUNT_WIDTH:0] diff;
	count_t            rem_nxt;
	logic              qbit;

	// one trial subtraction per cycle
	always_comb begin
		shifted = {rem_q, quot_q[COUNT_WIDTH-1]};
		diff    = shifted - {1'b0, dvs_q};
		qbit    = ~diff[COUNT_WIDTH];
		rem_nxt = qbit ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(COUNT_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			quot_q <= {quot_q[COUNT_WIDTH-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;
	assign rem       = rem_q;

endmodule

// File: src/per_class_rate_limiter_early_drop_core.sv
// top level of the per-class rate limiter with early drop
//
// Each transaction on the input stream is either a message (tuser = 0) whose tdata names a
// kind, or an interval tick (tuser = 1). A message of a limited class is counted and gets a
// pass or drop verdict on the output stream; a message of a class with a zero limit passes,
// other kinds get "not applicable". A tick gives no output and recomputes each limited
// class's load as count / limit. One shared restoring divider (one quotient bit per clock)
// does both the modulo of the early-drop check and the load division, and the block takes
// one transaction at a time. The output register lets the next transaction be accepted
// while a verdict still waits to be taken. Limits are to be written on the cfg port while
// idle; the block itself does not enforce this.
`include "assert_macros.svh"

module per_class_rate_limiter_early_drop_core
	import prcl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [2:0] msg_kind
	input  logic                  s_axis_tuser,  // [0] cmd
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [1:0] verdict
	// limit registers
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_idx,
	input  logic [COUNT_WIDTH-1:0] cfg_data
);

	state_t          state_q, state_d;
	logic [CLS_W-1:0] cls_q, cls_d;
	verdict_t        res_q, res_d;
	logic            out_valid_q;
	verdict_t        out_verdict_q;

	count_t limit_q [NUM_CLASSES];
	count_t count_q [NUM_CLASSES];
	count_t load_q  [NUM_CLASSES];
	logic   first_q [NUM_CLASSES];

	count_t    cur_lim, cur_cnt, cur_load, cnt_inc;
	logic      cur_first;
	logic      in_accept, is_class, out_load, cnt_wr, tick_wr;
	div_req_t  div_req;
	div_stat_t div_stat;
	count_t    div_quot, div_rem;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign is_class  = ({1'b0, s_axis_tdata[KIND_W-1:0]} < (KIND_W + 1)'(NUM_CLASSES));

	// state of the class in work
	assign cur_lim   = limit_q[cls_q];
	assign cur_cnt   = count_q[cls_q];
	assign cur_load  = load_q[cls_q];
	assign cur_first = first_q[cls_q];
	assign cnt_inc   = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

	prcl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cls_q   <= '0;
		end else begin
			state_q <= state_d;
			cls_q   <= cls_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	// sequencer next state and controls
	always_comb begin
		state_d          = state_q;
		cls_d            = cls_q;
		res_d            = res_q;
		s_axis_tready    = 1'b0;
		out_load         = 1'b0;
		cnt_wr           = 1'b0;
		tick_wr          = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = cur_cnt;
		div_req.divisor  = cur_lim;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == CMD_TICK) begin
						cls_d   = '0;
						state_d = ST_TICK;
					end else if (is_class) begin
						cls_d   = s_axis_tdata[CLS_W-1:0];
						state_d = ST_MSG;
					end else begin
						res_d   = VERDICT_NA;
						state_d = ST_RESULT;
					end
				end
			end
			ST_MSG: begin
				if (cur_lim == '0) begin
					res_d   = VERDICT_PASS;
					state_d = ST_RESULT;
				end else begin
					cnt_wr = 1'b1;
					if (cur_first) begin
						res_d   = (cnt_inc > cur_lim) ? VERDICT_DROP : VERDICT_PASS;
						state_d = ST_RESULT;
					end else if (cur_load <= count_t'(1)) begin
						res_d   = VERDICT_PASS;
						state_d = ST_RESULT;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = cnt_inc;
						div_req.divisor  = cur_load;
						state_d          = ST_MSG_DIV;
					end
				end
			end
			ST_MSG_DIV: begin
				if (div_stat.done) begin
					res_d   = (div_rem == '0) ? VERDICT_PASS : VERDICT_DROP;
					state_d = ST_RESULT;
				end
			end
			ST_TICK: begin
				if (cur_lim == '0) begin
					if (cls_q == CLS_W'(NUM_CLASSES - 1)) begin
						state_d = ST_IDLE;
					end else begin
						cls_d = cls_q + 1'b1;
					end
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_TICK_DIV;
				end
			end
			ST_TICK_DIV: begin
				if (div_stat.done) begin
					tick_wr = 1'b1;
					if (cls_q == CLS_W'(NUM_CLASSES - 1)) begin
						state_d = ST_IDLE;
					end else begin
						cls_d   = cls_q + 1'b1;
						state_d = ST_TICK;
					end
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				limit_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				if (cfg_idx == IDX_W'(i)) begin
					limit_q[i] <= cfg_data;
				end
			end
		end
	end

	// per-class count, load and first-interval mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				count_q[i] <= '0;
				load_q[i]  <= '0;
				first_q[i] <= 1'b1;
			end
		end else if (cnt_wr) begin
			count_q[cls_q] <= cnt_inc;
		end else if (tick_wr) begin
			count_q[cls_q] <= '0;
			load_q[cls_q]  <= div_quot;
			first_q[cls_q] <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_verdict_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - VERDICT_W){1'b0}}, out_verdict_q};

	// checks
	`ASSERT_RST(a_div_start_idle, div_req.start |-> !div_stat.busy, "divider started while busy")
	`ASSERT_RST(a_div_done_state, div_stat.done |-> (state_q == ST_MSG_DIV || state_q == ST_TICK_DIV), "divider result with no waiting step")
	`ASSERT_RST(a_tick_seq, (in_accept && s_axis_tuser == CMD_TICK) |=> (state_q == ST_TICK), "tick did not start the class sweep")
	`ASSERT_RST(a_res_code, (state_q == ST_RESULT) |-> (res_q == VERDICT_PASS || res_q == VERDICT_DROP || res_q == VERDICT_NA), "bad verdict code")
	`ASSERT_RST(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled verdict changed")

endmodule
